// File: rtl/flf_pkg.sv
// ----------------------------------------------------------------------------
// flf_pkg: shared constants and types for the flux-limited face flux block
// Holds the fixed-point format, the limiter mode codes and the constants
// that the front end, the dividers and the limiter stages all rely on.
// ----------------------------------------------------------------------------
`default_nettype none

package flf_pkg;

    // Default width of every cell value, speed and flux (signed Q8.16).
    localparam int VALUE_BITS_DEF = 24;

    // Fraction bits shared by every fixed-point quantity.
    localparam int FRAC_BITS = 16;

    // Integer bits of the slope ratio before it saturates at 256.0.
    localparam int THETA_INT_BITS = 8;

    // Quotient bits of the slope ratio divider and width of its magnitude.
    localparam int THETA_QUO_BITS = FRAC_BITS + THETA_INT_BITS;
    localparam int THETA_MAG_BITS = THETA_QUO_BITS + 1;

    // Width of a limiter value, which never exceeds 1.0.
    localparam int PHI_BITS = FRAC_BITS + 1;

    // Reciprocal of three, exact after a shift for operands below 2^32.
    localparam logic [31:0] THIRD_RECIP = 32'hAAAA_AAAB;
    localparam int          THIRD_SHIFT = 33;

    typedef enum logic [1:0] {
        LIM_NONE     = 2'd0,
        LIM_CENTERED = 2'd1,
        LIM_VAN_LEER = 2'd2,
        LIM_KOREN    = 2'd3
    } limiter_mode_t;

    localparam limiter_mode_t LIMITER_RESET = LIM_KOREN;

endpackage

`default_nettype wire

// File: rtl/flf_div.sv
// ----------------------------------------------------------------------------
// flf_div: pipelined restoring divider
// One quotient bit per register stage; a side word travels with each
// transaction so that the caller's context stays aligned with its quotient.
// ----------------------------------------------------------------------------
`default_nettype none

module flf_div #(
    parameter int DW = 25,
    parameter int QB = 16,
    parameter int SB = 8
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          en,
    input  wire logic          in_valid,
    input  wire logic [DW-1:0] in_rem,
    input  wire logic [DW-1:0] in_div,
    input  wire logic [QB-1:0] in_bits,
    input  wire logic [SB-1:0] in_side,
    output logic               out_valid,
    output logic [QB-1:0]      out_quo,
    output logic [SB-1:0]      out_side
);

    logic          lv_valid [QB+1];
    logic [DW-1:0] lv_rem   [QB+1];
    logic [DW-1:0] lv_div   [QB+1];
    logic [QB-1:0] lv_bits  [QB+1];
    logic [QB-1:0] lv_quo   [QB+1];
    logic [SB-1:0] lv_side  [QB+1];

    assign lv_valid[0] = in_valid;
    assign lv_rem[0]   = in_rem;
    assign lv_div[0]   = in_div;
    assign lv_bits[0]  = in_bits;
    assign lv_quo[0]   = '0;
    assign lv_side[0]  = in_side;

    for (genvar k = 0; k < QB; k++) begin : g_stage
        logic          valid_reg;
        logic [DW-1:0] rem_reg;
        logic [DW-1:0] div_reg;
        logic [QB-1:0] bits_reg;
        logic [QB-1:0] quo_reg;
        logic [SB-1:0] side_reg;
        logic [DW:0]   trial;
        logic [DW:0]   diff;
        logic          take;

        always_comb
        begin
            trial = {lv_rem[k], lv_bits[k][QB-1]};
            diff  = trial - {1'b0, lv_div[k]};
            take  = (trial >= {1'b0, lv_div[k]});
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg <= 1'b0;
            end
            else if (en)
            begin
                valid_reg <= lv_valid[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg  <= take ? diff[DW-1:0] : trial[DW-1:0];
                div_reg  <= lv_div[k];
                bits_reg <= {lv_bits[k][QB-2:0], 1'b0};
                quo_reg  <= {lv_quo[k][QB-2:0], take};
                side_reg <= lv_side[k];
            end
        end

        assign lv_valid[k+1] = valid_reg;
        assign lv_rem[k+1]   = rem_reg;
        assign lv_div[k+1]   = div_reg;
        assign lv_bits[k+1]  = bits_reg;
        assign lv_quo[k+1]   = quo_reg;
        assign lv_side[k+1]  = side_reg;
    end

    assign out_valid = lv_valid[QB];
    assign out_quo   = lv_quo[QB];
    assign out_side  = lv_side[QB];

endmodule

`default_nettype wire

// File: rtl/flux_limited_face_flux.sv
// ----------------------------------------------------------------------------
// flux_limited_face_flux: upwind face flux with a limited correction
// Takes four cell values in a line and the face speed, and returns the
// saturated flux through the face between the two middle cells.
// ----------------------------------------------------------------------------
// Usage:
// The input channel carries u_before, u_left, u_right, u_after and
// face_speed; a transaction is taken when in_valid is high and in_stall is
// low. The output channel returns one face_flux per input transaction under
// out_valid and out_stall, in order.
// Throughput is one transaction per cycle unless the pipeline is stalled.
// A transaction passes 49 register stages: three front stages, 24 stages
// of the slope ratio divider (one quotient bit per stage), one stage for
// the Koren reciprocal multiply, 16 stages of the van Leer divider, and
// five stages that select the limiter, form the correction and saturate
// the sum into the output register.
// The limiter mode is written through cfg_we and cfg_data and must only be
// changed while no transaction is in flight.
// Reset clears every valid bit and sets the limiter to Koren. When the
// receiver stalls while a result is held, the whole pipeline freezes and
// in_stall rises in the same cycle; nothing is lost or repeated.
// ----------------------------------------------------------------------------
`default_nettype none

module flux_limited_face_flux #(
    parameter int VALUE_BITS = flf_pkg::VALUE_BITS_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_we,
    input  wire logic [1:0]                   cfg_data,
    input  wire logic                         in_valid,
    output logic                              in_stall,
    input  wire logic signed [VALUE_BITS-1:0] u_before,
    input  wire logic signed [VALUE_BITS-1:0] u_left,
    input  wire logic signed [VALUE_BITS-1:0] u_right,
    input  wire logic signed [VALUE_BITS-1:0] u_after,
    input  wire logic signed [VALUE_BITS-1:0] face_speed,
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output logic signed [VALUE_BITS-1:0]      face_flux
);

    localparam int W   = VALUE_BITS;
    localparam int MW  = W + 1;          // magnitude of a difference
    localparam int FW  = 2 * W + 1;      // signed first-order flux
    localparam int FRAC = flf_pkg::FRAC_BITS;
    localparam int TIB = flf_pkg::THETA_INT_BITS;
    localparam int TQB = flf_pkg::THETA_QUO_BITS;
    localparam int TW  = flf_pkg::THETA_MAG_BITS;
    localparam int PB  = flf_pkg::PHI_BITS;
    localparam int KPW = TW + 32;        // Koren reciprocal product
    localparam int SB1 = W + 1 + MW + 1 + 1 + 1 + 1 + FW;
    localparam int SB2 = PB + W + 1 + MW + 1 + 1 + FW;

    // Output register, declared here because the stall logic reads it.
    logic                out_valid_reg;
    logic signed [W-1:0] face_flux_reg;

    // The pipeline moves as one unit unless a held result is stalled.
    logic adv;
    assign adv      = !(out_valid_reg && out_stall);
    assign in_stall = !adv;

    // Limiter mode register.
    flf_pkg::limiter_mode_t mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= flf_pkg::LIMITER_RESET;
        end
        else if (cfg_we)
        begin
            mode_reg <= flf_pkg::limiter_mode_t'(cfg_data);
        end
    end

    // ------------------------------------------------------------------
    // Stage 0: pick upwind, downwind and far values by the speed sign.
    // Zero speed counts as non-negative.
    // ------------------------------------------------------------------
    logic                s0_valid_reg;
    logic signed [W-1:0] up_reg, dn_reg, far_reg, a_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s0_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_reg <= face_speed;
            if (face_speed[W-1])
            begin
                up_reg  <= u_right;
                dn_reg  <= u_left;
                far_reg <= u_after;
            end
            else
            begin
                up_reg  <= u_left;
                dn_reg  <= u_right;
                far_reg <= u_before;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: differences, split into magnitude and sign.
    // ------------------------------------------------------------------
    logic signed [MW-1:0] num_s, den_s;
    logic [MW-1:0]        num_mag, den_mag;
    logic [W-1:0]         a_mag, up_mag;

    always_comb
    begin
        num_s   = {up_reg[W-1], up_reg} - {far_reg[W-1], far_reg};
        den_s   = {dn_reg[W-1], dn_reg} - {up_reg[W-1], up_reg};
        num_mag = num_s[MW-1] ? -num_s : num_s;
        den_mag = den_s[MW-1] ? -den_s : den_s;
        a_mag   = a_reg[W-1] ? -a_reg : a_reg;
        up_mag  = up_reg[W-1] ? -up_reg : up_reg;
    end

    logic          s1_valid_reg;
    logic [MW-1:0] s1_nmag_reg, s1_dmag_reg;
    logic          s1_dneg_reg, s1_tneg_reg, s1_en_reg;
    logic [W-1:0]  s1_amag_reg, s1_upmag_reg;
    logic          s1_aneg_reg, s1_fneg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= s0_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_nmag_reg  <= num_mag;
            s1_dmag_reg  <= den_mag;
            s1_dneg_reg  <= den_s[MW-1];
            s1_tneg_reg  <= num_s[MW-1] ^ den_s[MW-1];
            s1_en_reg    <= (mode_reg != flf_pkg::LIM_NONE) && (den_s != '0);
            s1_amag_reg  <= a_mag;
            s1_upmag_reg <= up_mag;
            s1_aneg_reg  <= a_reg[W-1];
            s1_fneg_reg  <= a_reg[W-1] ^ up_reg[W-1];
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: first-order product and the slope ratio saturation test.
    // ------------------------------------------------------------------
    logic            s2_valid_reg;
    logic [2*W-1:0]  s2_fprod_reg;
    logic            s2_sat_reg;
    logic [MW-1:0]   s2_nmag_reg, s2_dmag_reg;
    logic            s2_dneg_reg, s2_tneg_reg, s2_en_reg;
    logic [W-1:0]    s2_amag_reg;
    logic            s2_aneg_reg, s2_fneg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_fprod_reg <= (2*W)'(s1_amag_reg) * (2*W)'(s1_upmag_reg);
            s2_sat_reg   <= ({{TIB{1'b0}}, s1_nmag_reg} >= {s1_dmag_reg, {TIB{1'b0}}});
            s2_nmag_reg  <= s1_nmag_reg;
            s2_dmag_reg  <= s1_dmag_reg;
            s2_dneg_reg  <= s1_dneg_reg;
            s2_tneg_reg  <= s1_tneg_reg;
            s2_en_reg    <= s1_en_reg;
            s2_amag_reg  <= s1_amag_reg;
            s2_aneg_reg  <= s1_aneg_reg;
            s2_fneg_reg  <= s1_fneg_reg;
        end
    end

    // Rounded first-order flux, signed.
    logic [2*W-1:0]       flux1_mag;
    logic signed [FW-1:0] flux1;

    always_comb
    begin
        flux1_mag = (s2_fprod_reg + (2*W)'(1 << (FRAC - 1))) >> FRAC;
        flux1     = s2_fneg_reg ? -{1'b0, flux1_mag} : {1'b0, flux1_mag};
    end

    // ------------------------------------------------------------------
    // Slope ratio divider: |num| * 2^16 / |den|, one bit per stage.
    // ------------------------------------------------------------------
    logic [SB1-1:0] d1_side_in, d1_side_out;
    logic           d1_valid;
    logic [TQB-1:0] d1_quo;

    assign d1_side_in = {s2_amag_reg, s2_aneg_reg, s2_dmag_reg, s2_dneg_reg,
                         s2_en_reg, s2_sat_reg, s2_tneg_reg, flux1};

    flf_div #(
        .DW (MW),
        .QB (TQB),
        .SB (SB1)
    ) u_theta_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (s2_valid_reg),
        .in_rem    ({{TIB{1'b0}}, s2_nmag_reg[MW-1:TIB]}),
        .in_div    (s2_dmag_reg),
        .in_bits   ({s2_nmag_reg[TIB-1:0], {FRAC{1'b0}}}),
        .in_side   (d1_side_in),
        .out_valid (d1_valid),
        .out_quo   (d1_quo),
        .out_side  (d1_side_out)
    );

    logic [W-1:0]         d1_amag;
    logic                 d1_aneg;
    logic [MW-1:0]        d1_dmag;
    logic                 d1_dneg, d1_en, d1_sat, d1_tneg;
    logic signed [FW-1:0] d1_flux1;
    logic [TW-1:0]        theta_mag, theta_pos;

    always_comb
    begin
        {d1_amag, d1_aneg, d1_dmag, d1_dneg, d1_en, d1_sat, d1_tneg, d1_flux1} =
            d1_side_out;
        theta_mag = d1_sat ? (TW'(1) << TQB) : {1'b0, d1_quo};
        // Limiters other than the centered one are zero for theta <= 0.
        theta_pos = d1_tneg ? '0 : theta_mag;
    end

    // ------------------------------------------------------------------
    // Koren stage: (2 + theta) / 6 as ((2 + theta) / 2) * (1/3).
    // ------------------------------------------------------------------
    logic                 k_valid_reg;
    logic [TW-1:0]        k_thp_reg;
    logic [KPW-1:0]       k_prod_reg;
    logic [W-1:0]         k_amag_reg;
    logic                 k_aneg_reg;
    logic [MW-1:0]        k_dmag_reg;
    logic                 k_dneg_reg, k_en_reg;
    logic signed [FW-1:0] k_flux1_reg;
    logic [TW-1:0]        k_half;

    assign k_half = (TW'(1) << FRAC) + (theta_pos >> 1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            k_valid_reg <= d1_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            k_thp_reg   <= theta_pos;
            k_prod_reg  <= KPW'(k_half) * KPW'(flf_pkg::THIRD_RECIP);
            k_amag_reg  <= d1_amag;
            k_aneg_reg  <= d1_aneg;
            k_dmag_reg  <= d1_dmag;
            k_dneg_reg  <= d1_dneg;
            k_en_reg    <= d1_en;
            k_flux1_reg <= d1_flux1;
        end
    end

    logic [TW-1:0] k_z;
    logic [PB-1:0] k_phi;

    always_comb
    begin
        k_z = TW'(k_prod_reg >> flf_pkg::THIRD_SHIFT);
        if (k_thp_reg < k_z)
        begin
            k_z = k_thp_reg;
        end
        if (k_z > (TW'(1) << FRAC))
        begin
            k_z = TW'(1) << FRAC;
        end
        k_phi = k_z[PB-1:0];
    end

    // ------------------------------------------------------------------
    // van Leer divider: theta * 2^16 / (2^16 + theta).
    // ------------------------------------------------------------------
    logic [SB2-1:0]  d2_side_in, d2_side_out;
    logic            d2_valid;
    logic [FRAC-1:0] d2_quo;

    assign d2_side_in = {k_phi, k_amag_reg, k_aneg_reg, k_dmag_reg, k_dneg_reg,
                         k_en_reg, k_flux1_reg};

    flf_div #(
        .DW (TW),
        .QB (FRAC),
        .SB (SB2)
    ) u_vl_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (k_valid_reg),
        .in_rem    (k_thp_reg),
        .in_div    ((TW'(1) << FRAC) + k_thp_reg),
        .in_bits   ('0),
        .in_side   (d2_side_in),
        .out_valid (d2_valid),
        .out_quo   (d2_quo),
        .out_side  (d2_side_out)
    );

    logic [PB-1:0]        d2_kphi;
    logic [W-1:0]         d2_amag;
    logic                 d2_aneg;
    logic [MW-1:0]        d2_dmag;
    logic                 d2_dneg, d2_en;
    logic signed [FW-1:0] d2_flux1;
    logic [PB-1:0]        phi_sel;

    always_comb
    begin
        {d2_kphi, d2_amag, d2_aneg, d2_dmag, d2_dneg, d2_en, d2_flux1} = d2_side_out;
        case (mode_reg)
            flf_pkg::LIM_CENTERED: phi_sel = PB'(1) << (FRAC - 1);
            flf_pkg::LIM_VAN_LEER: phi_sel = {1'b0, d2_quo};
            flf_pkg::LIM_KOREN:    phi_sel = d2_kphi;
            default:               phi_sel = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Correction: p = round(phi * (dn - up)), corr = round(a * p).
    // ------------------------------------------------------------------
    logic                 p1_valid_reg;
    logic [PB-1:0]        p1_phi_reg;
    logic [W-1:0]         p1_amag_reg;
    logic [MW-1:0]        p1_dmag_reg;
    logic                 p1_cneg_reg, p1_en_reg;
    logic signed [FW-1:0] p1_flux1_reg;

    logic                 p2_valid_reg;
    logic [PB+MW-1:0]     p2_prod_reg;
    logic [W-1:0]         p2_amag_reg;
    logic                 p2_cneg_reg, p2_en_reg;
    logic signed [FW-1:0] p2_flux1_reg;

    logic                 p3_valid_reg;
    logic [MW:0]          p3_pmag_reg;
    logic [W-1:0]         p3_amag_reg;
    logic                 p3_cneg_reg, p3_en_reg;
    logic signed [FW-1:0] p3_flux1_reg;

    logic                 p4_valid_reg;
    logic [2*W+1:0]       p4_prod_reg;
    logic                 p4_cneg_reg, p4_en_reg;
    logic signed [FW-1:0] p4_flux1_reg;

    logic [PB+MW-1:0]     p_round;

    assign p_round = (p2_prod_reg + (PB+MW)'(1 << (FRAC - 1))) >> FRAC;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            p3_valid_reg <= 1'b0;
            p4_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            p1_valid_reg <= d2_valid;
            p2_valid_reg <= p1_valid_reg;
            p3_valid_reg <= p2_valid_reg;
            p4_valid_reg <= p3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p1_phi_reg   <= phi_sel;
            p1_amag_reg  <= d2_amag;
            p1_dmag_reg  <= d2_dmag;
            p1_cneg_reg  <= d2_aneg ^ d2_dneg;
            p1_en_reg    <= d2_en;
            p1_flux1_reg <= d2_flux1;

            p2_prod_reg  <= (PB+MW)'(p1_phi_reg) * (PB+MW)'(p1_dmag_reg);
            p2_amag_reg  <= p1_amag_reg;
            p2_cneg_reg  <= p1_cneg_reg;
            p2_en_reg    <= p1_en_reg;
            p2_flux1_reg <= p1_flux1_reg;

            p3_pmag_reg  <= p_round[MW:0];
            p3_amag_reg  <= p2_amag_reg;
            p3_cneg_reg  <= p2_cneg_reg;
            p3_en_reg    <= p2_en_reg;
            p3_flux1_reg <= p2_flux1_reg;

            p4_prod_reg  <= (2*W+2)'(p3_amag_reg) * (2*W+2)'(p3_pmag_reg);
            p4_cneg_reg  <= p3_cneg_reg;
            p4_en_reg    <= p3_en_reg;
            p4_flux1_reg <= p3_flux1_reg;
        end
    end

    // ------------------------------------------------------------------
    // Final stage: add the correction and saturate into the output register.
    // ------------------------------------------------------------------
    logic [2*W+1:0]          corr_mag;
    logic signed [2*W+2:0]   corr;
    logic signed [2*W+3:0]   flux_sum;
    logic signed [W-1:0]     flux_sat;
    logic signed [2*W+3:0]   lim_hi, lim_lo;

    always_comb
    begin
        corr_mag = (p4_prod_reg + (2*W+2)'(1 << (FRAC - 1))) >> FRAC;
        corr     = p4_cneg_reg ? -{1'b0, corr_mag} : {1'b0, corr_mag};
        if (!p4_en_reg)
        begin
            corr = '0;
        end
        flux_sum = (2*W+4)'(p4_flux1_reg) + (2*W+4)'(corr);
        lim_hi   = (2*W+4)'((64'sd1 <<< (W - 1)) - 64'sd1);
        lim_lo   = -(2*W+4)'(64'sd1 <<< (W - 1));
        if (flux_sum > lim_hi)
        begin
            flux_sat = lim_hi[W-1:0];
        end
        else if (flux_sum < lim_lo)
        begin
            flux_sat = lim_lo[W-1:0];
        end
        else
        begin
            flux_sat = flux_sum[W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= p4_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            face_flux_reg <= flux_sat;
        end
    end

    assign out_valid = out_valid_reg;
    assign face_flux = face_flux_reg;

endmodule

`default_nettype wire
